// File: hdl/sagpd_pkg.sv
// ----------------------------------------------------------------------------
// sagpd_pkg
// Shared types and constants for the emitter gain, pan and Doppler block.
// ----------------------------------------------------------------------------
package sagpd_pkg;

  localparam int POS_W      = 24;
  localparam int DIFF_W     = 25;
  localparam int DIST_IN_W  = 23;
  localparam int RVEC_W     = 16;
  localparam int SPEED_W    = 23;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int SQ_W       = 50;
  localparam int DIV_W      = 51;
  localparam int DEN_W      = 25;
  localparam int GSQ_W      = 32;
  localparam int PDIV_W     = 37;

  localparam int Q15_ONE   = 32768;
  localparam int Q14_ONE   = 16384;
  localparam int PITCH_MIN = 8192;
  localparam int PITCH_MAX = 32768;

  localparam logic [31:0] RECIP_5 = 32'hCCCC_CCCD;

  localparam int IQ_DEPTH = 4;
  localparam int OQ_DEPTH = 2;

  localparam logic signed [POS_W-1:0]  LISTENER_RST = '0;
  localparam logic signed [RVEC_W-1:0] RVX_RST      = 16'sd16384;
  localparam logic signed [RVEC_W-1:0] RVY_RST      = '0;
  localparam logic [SPEED_W-1:0]       SPEED_RST    = 23'd87808;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LISTENER_X = 3'd0,
    REG_LISTENER_Y = 3'd1,
    REG_LISTENER_Z = 3'd2,
    REG_RIGHT_X    = 3'd3,
    REG_RIGHT_Y    = 3'd4,
    REG_SPEED      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  lx;
    logic signed [POS_W-1:0]  ly;
    logic signed [POS_W-1:0]  lz;
    logic signed [RVEC_W-1:0] rx;
    logic signed [RVEC_W-1:0] ry;
    logic [SPEED_W-1:0]       c;
  } cfg_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
    logic signed [POS_W-1:0]  vx;
    logic signed [POS_W-1:0]  vy;
    logic signed [POS_W-1:0]  vz;
    logic [DIST_IN_W-1:0]     near_d;
    logic [DIST_IN_W-1:0]     far_d;
  } item_t;

  typedef struct packed {
    logic [15:0]        att;
    logic signed [16:0] pan;
    logic [15:0]        lg;
    logic [15:0]        rg;
    logic [15:0]        pitch;
  } result_t;

endpackage

// File: hdl/spatial_audio_gain_pan_doppler.sv
// ----------------------------------------------------------------------------
// spatial_audio_gain_pan_doppler
// Per-emitter distance attenuation, stereo pan, left/right gains and pitch.
// ----------------------------------------------------------------------------
//  channel  handshake               carries
//  in_      push / full             emitter position, velocity, near/far
//  out_     pop / empty             attenuation, pan, gains, pitch scale
//  cfg_     valid / ready (=1)      register index and data
//
//  One emitter per cycle sustained while the back pipeline advances; each
//  passes two square root pipelines and two divider pipelines in series.
//  A full result queue freezes the whole back pipeline; the input queue
//  keeps accepting until it fills. Reset restores the listener registers.
// ----------------------------------------------------------------------------
module spatial_audio_gain_pan_doppler import sagpd_pkg::*; #(
  parameter int IN_DEPTH  = IQ_DEPTH,
  parameter int OUT_DEPTH = OQ_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic signed [POS_W-1:0] in_emitter_x,
  input  logic signed [POS_W-1:0] in_emitter_y,
  input  logic signed [POS_W-1:0] in_emitter_z,
  input  logic signed [POS_W-1:0] in_vel_x,
  input  logic signed [POS_W-1:0] in_vel_y,
  input  logic signed [POS_W-1:0] in_vel_z,
  input  logic [DIST_IN_W-1:0]    in_near_distance,
  input  logic [DIST_IN_W-1:0]    in_far_distance,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic [15:0]             out_attenuation,
  output logic signed [16:0]      out_pan,
  output logic [15:0]             out_left_gain,
  output logic [15:0]             out_right_gain,
  output logic [15:0]             out_pitch_scale,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  cfg_t    cfg;
  item_t   item_in, item_q;
  result_t res, res_q;
  logic    iq_empty, back_rdy, res_vld, oq_full;

  assign cfg_ready = 1'b1;

  sagpd_front u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_emitter_x(in_emitter_x), .in_emitter_y(in_emitter_y),
    .in_emitter_z(in_emitter_z),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y), .in_vel_z(in_vel_z),
    .in_near_distance(in_near_distance), .in_far_distance(in_far_distance),
    .cfg(cfg), .item(item_in)
  );

  sagpd_fifo #(.DEPTH(IN_DEPTH), .W($bits(item_t))) u_in_q (
    .clk(clk), .rst_n(rst_n),
    .push(in_push), .din(item_in), .full(in_full),
    .pop(back_rdy), .dout(item_q), .empty(iq_empty)
  );

  sagpd_back u_back (
    .clk(clk), .rst_n(rst_n),
    .in_vld(!iq_empty), .item(item_q), .cfg(cfg), .in_rdy(back_rdy),
    .res_full(oq_full), .res_vld(res_vld), .res(res)
  );

  sagpd_fifo #(.DEPTH(OUT_DEPTH), .W($bits(result_t))) u_out_q (
    .clk(clk), .rst_n(rst_n),
    .push(res_vld), .din(res), .full(oq_full),
    .pop(out_pop), .dout(res_q), .empty(out_empty)
  );

  assign out_attenuation = res_q.att;
  assign out_pan         = res_q.pan;
  assign out_left_gain   = res_q.lg;
  assign out_right_gain  = res_q.rg;
  assign out_pitch_scale = res_q.pitch;

endmodule

// File: hdl/sagpd_fifo.sv
// ----------------------------------------------------------------------------
// sagpd_fifo
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module sagpd_fifo import sagpd_pkg::*; #(
  parameter int DEPTH = IQ_DEPTH,
  parameter int W     = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule

// File: hdl/sagpd_isqrt.sv
// ----------------------------------------------------------------------------
// sagpd_isqrt
// Pipelined floor square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module sagpd_isqrt import sagpd_pkg::*; #(
  parameter int IW = SQ_W,
  parameter int TW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [IW-1:0]   in_val,
  input  logic [TW-1:0]   in_tag,
  output logic            out_vld,
  output logic [IW/2-1:0] out_root,
  output logic [TW-1:0]   out_tag
);

  localparam int RW   = IW / 2;
  localparam int REMW = RW + 2;

  logic [REMW-1:0] rem_r  [RW];
  logic [REMW-1:0] rem_nxt[RW];
  logic [RW-1:0]   root_r  [RW];
  logic [RW-1:0]   root_nxt[RW];
  logic [IW-1:0]   val_r  [RW];
  logic [IW-1:0]   val_nxt[RW];
  logic [TW-1:0]   tag_r  [RW];
  logic [TW-1:0]   tag_nxt[RW];
  logic [RW-1:0]   vld_r, vld_nxt;

  always_comb begin
    logic [REMW-1:0] rem_i;
    logic [RW-1:0]   root_i;
    logic [IW-1:0]   val_i;
    logic [REMW+1:0] acc;
    logic [REMW+1:0] trial;
    for (int s = 0; s < RW; s++) begin
      if (s == 0) begin
        rem_i      = '0;
        root_i     = '0;
        val_i      = in_val;
        tag_nxt[s] = in_tag;
        vld_nxt[s] = in_vld;
      end else begin
        rem_i      = rem_r[s-1];
        root_i     = root_r[s-1];
        val_i      = val_r[s-1];
        tag_nxt[s] = tag_r[s-1];
        vld_nxt[s] = vld_r[s-1];
      end
      acc   = {rem_i, val_i[IW-1 -: 2]};
      trial = acc - (REMW+2)'({root_i, 2'b01});
      if (!trial[REMW+1]) begin
        rem_nxt[s]  = trial[REMW-1:0];
        root_nxt[s] = {root_i[RW-2:0], 1'b1};
      end else begin
        rem_nxt[s]  = acc[REMW-1:0];
        root_nxt[s] = {root_i[RW-2:0], 1'b0};
      end
      val_nxt[s] = {val_i[IW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      val_r  <= val_nxt;
      tag_r  <= tag_nxt;
    end
  end

  assign out_vld  = vld_r[RW-1];
  assign out_root = root_r[RW-1];
  assign out_tag  = tag_r[RW-1];

endmodule

// File: hdl/sagpd_div.sv
// ----------------------------------------------------------------------------
// sagpd_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module sagpd_div import sagpd_pkg::*; #(
  parameter int NW  = DIV_W,
  parameter int DDW = DEN_W,
  parameter int TW  = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  logic [NW-1:0]  in_num,
  input  logic [DDW-1:0] in_den,
  input  logic [TW-1:0]  in_tag,
  output logic           out_vld,
  output logic [NW-1:0]  out_quo,
  output logic [TW-1:0]  out_tag
);

  logic [DDW-1:0] rem_r  [NW];
  logic [DDW-1:0] rem_nxt[NW];
  logic [NW-1:0]  nq_r  [NW];
  logic [NW-1:0]  nq_nxt[NW];
  logic [DDW-1:0] den_r  [NW];
  logic [DDW-1:0] den_nxt[NW];
  logic [TW-1:0]  tag_r  [NW];
  logic [TW-1:0]  tag_nxt[NW];
  logic [NW-1:0]  vld_r, vld_nxt;

  always_comb begin
    logic [DDW-1:0] rem_i;
    logic [NW-1:0]  nq_i;
    logic [DDW:0]   acc;
    logic [DDW:0]   diff;
    for (int s = 0; s < NW; s++) begin
      if (s == 0) begin
        rem_i      = '0;
        nq_i       = in_num;
        den_nxt[s] = in_den;
        tag_nxt[s] = in_tag;
        vld_nxt[s] = in_vld;
      end else begin
        rem_i      = rem_r[s-1];
        nq_i       = nq_r[s-1];
        den_nxt[s] = den_r[s-1];
        tag_nxt[s] = tag_r[s-1];
        vld_nxt[s] = vld_r[s-1];
      end
      acc  = {rem_i, nq_i[NW-1]};
      diff = acc - {1'b0, den_nxt[s]};
      if (acc >= {1'b0, den_nxt[s]}) begin
        rem_nxt[s] = diff[DDW-1:0];
        nq_nxt[s]  = {nq_i[NW-2:0], 1'b1};
      end else begin
        rem_nxt[s] = acc[DDW-1:0];
        nq_nxt[s]  = {nq_i[NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      nq_r  <= nq_nxt;
      den_r <= den_nxt;
      tag_r <= tag_nxt;
    end
  end

  assign out_vld = vld_r[NW-1];
  assign out_quo = nq_r[NW-1];
  assign out_tag = tag_r[NW-1];

endmodule

// File: hdl/sagpd_front.sv
// ----------------------------------------------------------------------------
// sagpd_front
// Configuration registers and offset of each emitter from the listener.
// ----------------------------------------------------------------------------
module sagpd_front import sagpd_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [POS_W-1:0]     in_emitter_x,
  input  logic signed [POS_W-1:0]     in_emitter_y,
  input  logic signed [POS_W-1:0]     in_emitter_z,
  input  logic signed [POS_W-1:0]     in_vel_x,
  input  logic signed [POS_W-1:0]     in_vel_y,
  input  logic signed [POS_W-1:0]     in_vel_z,
  input  logic [DIST_IN_W-1:0]        in_near_distance,
  input  logic [DIST_IN_W-1:0]        in_far_distance,
  output cfg_t                        cfg,
  output item_t                       item
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_LISTENER_X: cfg_nxt.lx = cfg_data;
        REG_LISTENER_Y: cfg_nxt.ly = cfg_data;
        REG_LISTENER_Z: cfg_nxt.lz = cfg_data;
        REG_RIGHT_X:    cfg_nxt.rx = cfg_data[RVEC_W-1:0];
        REG_RIGHT_Y:    cfg_nxt.ry = cfg_data[RVEC_W-1:0];
        REG_SPEED:      cfg_nxt.c  = cfg_data[SPEED_W-1:0];
        default:        cfg_nxt    = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lx <= LISTENER_RST;
      cfg_r.ly <= LISTENER_RST;
      cfg_r.lz <= LISTENER_RST;
      cfg_r.rx <= RVX_RST;
      cfg_r.ry <= RVY_RST;
      cfg_r.c  <= SPEED_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

  always_comb begin
    item.dx     = {in_emitter_x[POS_W-1], in_emitter_x} - {cfg_r.lx[POS_W-1], cfg_r.lx};
    item.dy     = {in_emitter_y[POS_W-1], in_emitter_y} - {cfg_r.ly[POS_W-1], cfg_r.ly};
    item.dz     = {in_emitter_z[POS_W-1], in_emitter_z} - {cfg_r.lz[POS_W-1], cfg_r.lz};
    item.vx     = in_vel_x;
    item.vy     = in_vel_y;
    item.vz     = in_vel_z;
    item.near_d = in_near_distance;
    item.far_d  = in_far_distance;
  end

endmodule

// File: hdl/sagpd_back.sv
// ----------------------------------------------------------------------------
// sagpd_back
// Distance, attenuation, pan, gains and pitch pipeline; stalls as one unit.
// ----------------------------------------------------------------------------
module sagpd_back import sagpd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_vld,
  input  item_t   item,
  input  cfg_t    cfg,
  output logic    in_rdy,
  input  logic    res_full,
  output logic    res_vld,
  output result_t res
);

  typedef enum logic [1:0] {ATT_FULL, ATT_ZERO, ATT_DIV} att_case_t;

  logic adv;

  // products
  logic                       a_vld_r;
  logic signed [49:0]         a_sxx_r, a_syy_r, a_szz_r;
  logic signed [40:0]         a_pxr_r, a_pyr_r;
  logic signed [48:0]         a_vdx_r, a_vdy_r, a_vdz_r;
  logic [DIST_IN_W-1:0]       a_near_r, a_far_r;

  // sums
  logic                       b_vld_r;
  logic [SQ_W-1:0]            b_p2_r, b_d2_r, b_p2_nxt;
  logic signed [41:0]         b_num_r;
  logic signed [50:0]         b_dot_r;
  logic [DIST_IN_W-1:0]       b_near_r, b_far_r;

  // distances
  logic                       s_vld1, s_vld2, s_vld;
  logic [DEN_W-1:0]           s_dist, s_planar;
  logic signed [41:0]         s_num;
  logic signed [50:0]         s_dot;
  logic [DIST_IN_W-1:0]       s_near, s_far;
  logic                       s_p2nz, s_d2nz;

  // divider setup
  logic                       c_vld_r;
  att_case_t                  c_case_r, c_case_nxt;
  logic [DIV_W-1:0]           c_att_num_r, c_pan_num_r, c_app_num_r;
  logic [DEN_W-1:0]           c_att_den_r, c_pan_den_r, c_app_den_r;
  logic                       c_num_neg_r, c_dot_neg_r, c_p2nz_r, c_d2nz_r;
  logic [DEN_W-1:0]           c_fmd;
  logic [41:0]                c_num_mag;
  logic [50:0]                c_dot_mag;

  // quotients
  logic                       q_vld1, q_vld2, q_vld3, q_vld;
  logic [DIV_W-1:0]           q_att, q_pan, q_app;
  logic [1:0]                 q_case;
  logic                       q_num_neg, q_p2nz, q_dot_neg, q_d2nz;

  // results of division
  logic                       e_vld_r;
  logic [15:0]                e_att_r, e_att_nxt;
  logic signed [16:0]         e_pan_r, e_pan_nxt;
  logic [DIV_W-1:0]           e_am_r;
  logic [SPEED_W-1:0]         e_lim_r;
  logic                       e_dot_neg_r, e_d2nz_r;
  logic [16:0]                e_q;
  logic [56:0]                e_lim_prod;

  // Doppler denominator and gain square roots
  logic                       f_vld_r;
  logic [15:0]                f_att_r;
  logic signed [16:0]         f_pan_r;
  logic [SPEED_W:0]           f_denom_r;
  logic                       f_d2nz_r;
  logic [GSQ_W-1:0]           f_lin_r, f_rin_r;
  logic [SPEED_W-1:0]         f_am;
  logic [17:0]                f_lv, f_rv;

  logic                       r_vld1, r_vld2, r_vld;
  logic [15:0]                r_sl, r_sr;
  logic [15:0]                r_att;
  logic signed [16:0]         r_pan;
  logic [SPEED_W:0]           r_denom;
  logic                       r_d2nz;

  logic                       g_vld_r;
  logic [15:0]                g_att_r, g_lg_r, g_rg_r;
  logic signed [16:0]         g_pan_r;
  logic [SPEED_W:0]           g_denom_r;
  logic                       g_d2nz_r;
  logic [31:0]                g_lprod, g_rprod;

  logic                       p_vld;
  logic [PDIV_W-1:0]          p_quo;
  logic [65:0]                p_tag;

  logic                       h_vld_r;
  result_t                    h_res_r, h_res_nxt;

  assign adv    = !(h_vld_r && res_full);
  assign in_rdy = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
      g_vld_r <= 1'b0;
      h_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= s_vld;
      e_vld_r <= q_vld;
      f_vld_r <= e_vld_r;
      g_vld_r <= r_vld;
      h_vld_r <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_sxx_r  <= item.dx * item.dx;
      a_syy_r  <= item.dy * item.dy;
      a_szz_r  <= item.dz * item.dz;
      a_pxr_r  <= item.dx * cfg.rx;
      a_pyr_r  <= item.dy * cfg.ry;
      a_vdx_r  <= item.vx * item.dx;
      a_vdy_r  <= item.vy * item.dy;
      a_vdz_r  <= item.vz * item.dz;
      a_near_r <= item.near_d;
      a_far_r  <= item.far_d;
    end
  end

  assign b_p2_nxt = $unsigned(a_sxx_r) + $unsigned(a_syy_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      b_p2_r   <= b_p2_nxt;
      b_d2_r   <= b_p2_nxt + $unsigned(a_szz_r);
      b_num_r  <= {a_pxr_r[40], a_pxr_r} + {a_pyr_r[40], a_pyr_r};
      b_dot_r  <= {{2{a_vdx_r[48]}}, a_vdx_r} + {{2{a_vdy_r[48]}}, a_vdy_r}
                + {{2{a_vdz_r[48]}}, a_vdz_r};
      b_near_r <= a_near_r;
      b_far_r  <= a_far_r;
    end
  end

  sagpd_isqrt #(.IW(SQ_W), .TW(93)) u_sqrt_dist (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_vld(b_vld_r), .in_val(b_d2_r), .in_tag({b_num_r, b_dot_r}),
    .out_vld(s_vld1), .out_root(s_dist), .out_tag({s_num, s_dot})
  );

  sagpd_isqrt #(.IW(SQ_W), .TW(48)) u_sqrt_planar (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_vld(b_vld_r), .in_val(b_p2_r),
    .in_tag({b_near_r, b_far_r, |b_p2_r, |b_d2_r}),
    .out_vld(s_vld2), .out_root(s_planar), .out_tag({s_near, s_far, s_p2nz, s_d2nz})
  );

  assign s_vld = s_vld1 && s_vld2;

  always_comb begin
    if (s_dist <= DEN_W'(s_near)) begin
      c_case_nxt = ATT_FULL;
    end else if (s_dist >= DEN_W'(s_far)) begin
      c_case_nxt = ATT_ZERO;
    end else begin
      c_case_nxt = ATT_DIV;
    end
    c_fmd     = DEN_W'(s_far) - s_dist;
    c_num_mag = s_num[41] ? 42'(-s_num) : 42'(s_num);
    c_dot_mag = s_dot[50] ? 51'(-s_dot) : 51'(s_dot);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_case_r    <= c_case_nxt;
      c_att_num_r <= DIV_W'({c_fmd[DIST_IN_W-1:0], 15'd0});
      c_att_den_r <= DEN_W'(s_far - s_near);
      c_pan_num_r <= DIV_W'({c_num_mag, 1'b0});
      c_pan_den_r <= s_planar;
      c_app_num_r <= c_dot_mag;
      c_app_den_r <= s_dist;
      c_num_neg_r <= s_num[41];
      c_dot_neg_r <= s_dot[50];
      c_p2nz_r    <= s_p2nz;
      c_d2nz_r    <= s_d2nz;
    end
  end

  sagpd_div #(.NW(DIV_W), .DDW(DEN_W), .TW(2)) u_div_att (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_vld(c_vld_r), .in_num(c_att_num_r), .in_den(c_att_den_r), .in_tag(c_case_r),
    .out_vld(q_vld1), .out_quo(q_att), .out_tag(q_case)
  );

  sagpd_div #(.NW(DIV_W), .DDW(DEN_W), .TW(2)) u_div_pan (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_vld(c_vld_r), .in_num(c_pan_num_r), .in_den(c_pan_den_r),
    .in_tag({c_num_neg_r, c_p2nz_r}),
    .out_vld(q_vld2), .out_quo(q_pan), .out_tag({q_num_neg, q_p2nz})
  );

  sagpd_div #(.NW(DIV_W), .DDW(DEN_W), .TW(2)) u_div_app (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_vld(c_vld_r), .in_num(c_app_num_r), .in_den(c_app_den_r),
    .in_tag({c_dot_neg_r, c_d2nz_r}),
    .out_vld(q_vld3), .out_quo(q_app), .out_tag({q_dot_neg, q_d2nz})
  );

  assign q_vld = q_vld1 && q_vld2 && q_vld3;

  always_comb begin
    case (att_case_t'(q_case))
      ATT_FULL: e_att_nxt = 16'(Q15_ONE);
      ATT_ZERO: e_att_nxt = '0;
      ATT_DIV:  e_att_nxt = q_att[15:0];
      default:  e_att_nxt = '0;
    endcase
    e_q = (q_pan > DIV_W'(Q15_ONE)) ? 17'(Q15_ONE) : q_pan[16:0];
    if (!q_p2nz) begin
      e_pan_nxt = '0;
    end else if (q_num_neg) begin
      e_pan_nxt = -$signed(e_q);
    end else begin
      e_pan_nxt = $signed(e_q);
    end
    e_lim_prod = 57'({cfg.c, 2'b00}) * 57'(RECIP_5);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_att_r     <= e_att_nxt;
      e_pan_r     <= e_pan_nxt;
      e_am_r      <= q_app;
      e_lim_r     <= e_lim_prod[56:34];
      e_dot_neg_r <= q_dot_neg;
      e_d2nz_r    <= q_d2nz;
    end
  end

  always_comb begin
    f_am = (e_am_r > DIV_W'(e_lim_r)) ? e_lim_r : e_am_r[SPEED_W-1:0];
    f_lv = 18'(Q15_ONE) - {e_pan_r[16], e_pan_r};
    f_rv = 18'(Q15_ONE) + {e_pan_r[16], e_pan_r};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_att_r   <= e_att_r;
      f_pan_r   <= e_pan_r;
      f_denom_r <= e_dot_neg_r ? ({1'b0, cfg.c} - {1'b0, f_am})
                               : ({1'b0, cfg.c} + {1'b0, f_am});
      f_d2nz_r  <= e_d2nz_r;
      f_lin_r   <= {1'b0, f_lv[16:0], 14'd0};
      f_rin_r   <= {1'b0, f_rv[16:0], 14'd0};
    end
  end

  sagpd_isqrt #(.IW(GSQ_W), .TW(33)) u_sqrt_left (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_vld(f_vld_r), .in_val(f_lin_r), .in_tag({f_att_r, f_pan_r}),
    .out_vld(r_vld1), .out_root(r_sl), .out_tag({r_att, r_pan})
  );

  sagpd_isqrt #(.IW(GSQ_W), .TW(25)) u_sqrt_right (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_vld(f_vld_r), .in_val(f_rin_r), .in_tag({f_denom_r, f_d2nz_r}),
    .out_vld(r_vld2), .out_root(r_sr), .out_tag({r_denom, r_d2nz})
  );

  assign r_vld   = r_vld1 && r_vld2;
  assign g_lprod = r_sl * r_att;
  assign g_rprod = r_sr * r_att;

  always_ff @(posedge clk) begin
    if (adv) begin
      g_att_r   <= r_att;
      g_pan_r   <= r_pan;
      g_lg_r    <= g_lprod[30:15];
      g_rg_r    <= g_rprod[30:15];
      g_denom_r <= r_denom;
      g_d2nz_r  <= r_d2nz;
    end
  end

  sagpd_div #(.NW(PDIV_W), .DDW(DEN_W), .TW(66)) u_div_pitch (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_vld(g_vld_r), .in_num({cfg.c, 14'd0}), .in_den(DEN_W'(g_denom_r)),
    .in_tag({g_att_r, g_pan_r, g_lg_r, g_rg_r, g_d2nz_r}),
    .out_vld(p_vld), .out_quo(p_quo), .out_tag(p_tag)
  );

  always_comb begin
    h_res_nxt.att = p_tag[65:50];
    h_res_nxt.pan = p_tag[49:33];
    h_res_nxt.lg  = p_tag[32:17];
    h_res_nxt.rg  = p_tag[16:1];
    if (!p_tag[0] || (cfg.c == '0)) begin
      h_res_nxt.pitch = 16'(Q14_ONE);
    end else if (p_quo < PDIV_W'(PITCH_MIN)) begin
      h_res_nxt.pitch = 16'(PITCH_MIN);
    end else if (p_quo > PDIV_W'(PITCH_MAX)) begin
      h_res_nxt.pitch = 16'(PITCH_MAX);
    end else begin
      h_res_nxt.pitch = p_quo[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_res_r <= h_res_nxt;
    end
  end

  assign res_vld = h_vld_r;
  assign res     = h_res_r;

endmodule

// File: tb/spatial_audio_gain_pan_doppler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spatial_audio_gain_pan_doppler_tb
// Self-checking bench for the emitter gain, pan and Doppler block. Emitter
// words are predicted in-bench from the listener registers, queued, and
// compared field by field with each popped result. Directed corner emitters
// come first, then random emitters across several register settings, with
// random idle on both sides, a long output hold-off and full drains.
// ----------------------------------------------------------------------------
module spatial_audio_gain_pan_doppler_tb;
  import sagpd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd7;

  typedef struct {
    logic signed [POS_W-1:0] x, y, z, vx, vy, vz;
    logic [DIST_IN_W-1:0]    nr, fr;
  } emitter_t;

  class emitter_scoreboard;
    result_t pending[$];
    int      errors;
    int      checked;

    function void note(result_t r);
      pending.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check(result_t g);
      result_t e;
      if (pending.size() == 0) begin
        report("unexpected word", 0, 0);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (g.att !== e.att) report("attenuation", g.att, e.att);
      if (g.pan !== e.pan) report("pan", $signed(g.pan), $signed(e.pan));
      if (g.lg !== e.lg) report("left_gain", g.lg, e.lg);
      if (g.rg !== e.rg) report("right_gain", g.rg, e.rg);
      if (g.pitch !== e.pitch) report("pitch_scale", g.pitch, e.pitch);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_push = 0;
  logic in_full;
  logic signed [POS_W-1:0] in_emitter_x = 0, in_emitter_y = 0, in_emitter_z = 0;
  logic signed [POS_W-1:0] in_vel_x = 0, in_vel_y = 0, in_vel_z = 0;
  logic [DIST_IN_W-1:0] in_near_distance = 0, in_far_distance = 0;
  logic out_empty;
  logic out_pop = 0;
  logic [15:0] out_attenuation, out_left_gain, out_right_gain, out_pitch_scale;
  logic signed [16:0] out_pan;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [CFG_DATA_W-1:0] cfg_data = 0;

  emitter_scoreboard sb = new();
  cfg_t regs;
  bit   quiet = 0;
  bit   hold_go = 0;
  int   hold_left = 0;
  int   sent = 0;
  int   cfg_writes = 0;

  spatial_audio_gain_pan_doppler uut (.*);

  always #10 clk = ~clk;

  function automatic longint unsigned root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic result_t spatialize(emitter_t e);
    longint dx, dy, dz, rx, ry, num, dot, pan;
    longint unsigned p2, d2, d_len, att, q, sl, sr, c, am, lim, den, pitch;
    result_t r;
    dx = longint'(e.x) - longint'($signed(regs.lx));
    dy = longint'(e.y) - longint'($signed(regs.ly));
    dz = longint'(e.z) - longint'($signed(regs.lz));
    rx = longint'($signed(regs.rx));
    ry = longint'($signed(regs.ry));
    c = regs.c;
    p2 = dx * dx + dy * dy;
    d2 = p2 + dz * dz;
    d_len = root(d2);
    if (d_len <= e.nr) att = Q15_ONE;
    else if (d_len >= e.fr) att = 0;
    else att = ((e.fr - d_len) * Q15_ONE) / (e.fr - e.nr);
    pan = 0;
    if (p2 != 0) begin
      num = dx * rx + dy * ry;
      q = (mag(num) << 1) / root(p2);
      if (q > Q15_ONE) q = Q15_ONE;
      pan = num < 0 ? -longint'(q) : longint'(q);
    end
    sl = root(longint'(Q15_ONE - pan) << 14);
    sr = root(longint'(Q15_ONE + pan) << 14);
    pitch = Q14_ONE;
    if (d2 != 0 && c != 0) begin
      dot = longint'(e.vx) * dx + longint'(e.vy) * dy + longint'(e.vz) * dz;
      am = mag(dot) / d_len;
      lim = (c * 4) / 5;
      if (am > lim) am = lim;
      den = dot < 0 ? c - am : c + am;
      pitch = (c << 14) / den;
      if (pitch < PITCH_MIN) pitch = PITCH_MIN;
      if (pitch > PITCH_MAX) pitch = PITCH_MAX;
    end
    r.att = att[15:0];
    r.pan = pan[16:0];
    r.lg = 16'((sl * att) >> 15);
    r.rg = 16'((sr * att) >> 15);
    r.pitch = pitch[15:0];
    return r;
  endfunction

  function automatic emitter_t mk(int x, int y, int z, int vx, int vy, int vz,
                                  int nr, int fr);
    emitter_t e;
    e.x = POS_W'(x); e.y = POS_W'(y); e.z = POS_W'(z);
    e.vx = POS_W'(vx); e.vy = POS_W'(vy); e.vz = POS_W'(vz);
    e.nr = DIST_IN_W'(nr); e.fr = DIST_IN_W'(fr);
    return e;
  endfunction

  // random value of random magnitude, both signs
  function automatic logic signed [POS_W-1:0] rnd_s();
    logic signed [POS_W-1:0] v;
    v = POS_W'($urandom);
    return v >>> $urandom_range(0, POS_W - 1);
  endfunction

  function automatic logic [DIST_IN_W-1:0] rnd_d();
    logic [DIST_IN_W-1:0] v;
    v = DIST_IN_W'($urandom);
    return v >> $urandom_range(0, DIST_IN_W - 1);
  endfunction

  function automatic emitter_t rnd_emitter();
    emitter_t e;
    int mode;
    mode = $urandom_range(0, 99);
    e.vx = rnd_s(); e.vy = rnd_s(); e.vz = rnd_s();
    if (mode < 75) begin
      // emitter around the listener, far distance mostly set beyond near
      e.x = regs.lx + rnd_s();
      e.y = regs.ly + rnd_s();
      e.z = regs.lz + ($urandom_range(0, 3) == 0 ? 24'sd0 : rnd_s());
      e.nr = rnd_d();
      e.fr = e.nr + rnd_d();
      if ($urandom_range(0, 9) == 0) e.fr = rnd_d();
    end else begin
      e.x = POS_W'($urandom); e.y = POS_W'($urandom); e.z = POS_W'($urandom);
      e.nr = DIST_IN_W'($urandom); e.fr = DIST_IN_W'($urandom);
    end
    return e;
  endfunction

  task automatic send(emitter_t e);
    bit acc;
    while (!quiet && $urandom_range(0, 99) < 15) begin
      in_push <= 0;
      @(posedge clk);
    end
    in_emitter_x <= e.x; in_emitter_y <= e.y; in_emitter_z <= e.z;
    in_vel_x <= e.vx; in_vel_y <= e.vy; in_vel_z <= e.vz;
    in_near_distance <= e.nr; in_far_distance <= e.fr;
    in_push <= 1;
    do begin
      @(negedge clk);
      acc = !in_full;
      @(posedge clk);
    end while (!acc);
    sb.note(spatialize(e));
    sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    bit acc;
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1;
    do begin
      @(negedge clk);
      acc = cfg_ready;
      @(posedge clk);
    end while (!acc);
    cfg_valid <= 0;
    cfg_writes++;
    case (idx)
      REG_LISTENER_X: regs.lx = d;
      REG_LISTENER_Y: regs.ly = d;
      REG_LISTENER_Z: regs.lz = d;
      REG_RIGHT_X:    regs.rx = d[RVEC_W-1:0];
      REG_RIGHT_Y:    regs.ry = d[RVEC_W-1:0];
      REG_SPEED:      regs.c = d[SPEED_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(int lx, int ly, int lz, int rx, int ry, int c);
    write_reg(REG_LISTENER_X, CFG_DATA_W'(lx));
    write_reg(REG_LISTENER_Y, CFG_DATA_W'(ly));
    write_reg(REG_LISTENER_Z, CFG_DATA_W'(lz));
    write_reg(REG_RIGHT_X, CFG_DATA_W'(rx));
    write_reg(REG_RIGHT_Y, CFG_DATA_W'(ry));
    write_reg(REG_SPEED, CFG_DATA_W'(c));
  endtask

  task automatic drain();
    in_push <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    repeat (n) send(rnd_emitter());
    drain();
  endtask

  always @(posedge clk) begin
    if (hold_go) begin
      hold_go = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_pop <= 0;
    end else begin
      out_pop <= quiet || $urandom_range(0, 99) >= 15;
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_pop && !out_empty)
      sb.check('{out_attenuation, out_pan, out_left_gain, out_right_gain,
                 out_pitch_scale});
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    regs = '{LISTENER_RST, LISTENER_RST, LISTENER_RST, RVX_RST, RVY_RST, SPEED_RST};
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed corners at reset settings
    send(mk(0, 0, 0, 100, 0, 0, 0, 0));                       // coincident
    send(mk(0, 0, 2560, 0, 0, -5000, 256, 5120));             // on axis, plane zero
    send(mk(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608, 0, 8388607));
    send(mk(8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
    send(mk(8388607, -8388608, 0, -8388608, 8388607, 0, 8388607, 0));
    send(mk(2560, 0, 0, -8388608, 0, 0, 0, 5120));            // fast approach
    send(mk(2560, 0, 0, 8388607, 0, 0, 0, 5120));             // fast recede
    send(mk(-2560, 0, 0, 22000, 0, 0, 256, 5120));
    send(mk(0, 2560, 0, 0, 0, 0, 1024, 1024));                // near equals far
    send(mk(2560, 2560, 0, 0, -4000, 0, 8000, 100));          // far below near
    send(mk(2560, 2560, 0, 0, 0, 0, 100, 8000));
    send(mk(1, 0, 0, 0, 0, 0, 0, 1));
    send(mk(-1, 0, 0, 0, 0, 0, 0, 2));
    send(mk(0, -1, -1, 1, 1, 1, 1, 3));
    send(mk(3000, 0, 0, 0, 0, 0, 2999, 3001));
    send(mk(-3000, 0, 4000, 0, 0, 0, 1000, 6000));
    drain();

    // assorted settings, extremes among them
    write_all($urandom, $urandom, $urandom, $urandom_range(0, 32768) - 16384,
              $urandom_range(0, 32768) - 16384, $urandom_range(1, 8388607));
    random_phase(300);

    write_all(8388607, -8388608, 8388607, -16384, 16384, 8388607);
    quiet = 1;
    fork
      random_phase(150);
      begin
        @(negedge clk);
        hold_go = 1;
      end
    join
    quiet = 0;
    random_phase(150);

    write_all(-8388608, 8388607, -8388608, 16384, -16384, 1);
    send(mk(-8388600, 8388600, -8388608, 5000, -5000, 0, 0, 8388607));
    random_phase(250);

    // zero speed and writes to unused indexes
    write_reg(REG_SPEED, '0);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    write_reg(REG_TOP, CFG_DATA_W'($urandom));
    send(mk(5000, 0, 0, -8388608, 0, 0, 0, 10000));
    random_phase(100);

    write_all(256 * $urandom_range(0, 40), -256 * $urandom_range(0, 40), 0,
              11585, 11585, 87808);
    quiet = 1;
    random_phase(400);
    quiet = 0;

    write_all(0, 0, 0, 16384, 0, 87808);
    random_phase(450);

    repeat (300) @(posedge clk);
    $display("covered %0d emitters, %0d words checked, %0d register writes",
             sent, sb.checked, cfg_writes);
    $display("settings spanned listener extremes, zero and maximum sound speed");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: spatial_audio_gain_pan_doppler.f
hdl/sagpd_pkg.sv
hdl/sagpd_fifo.sv
hdl/sagpd_isqrt.sv
hdl/sagpd_div.sv
hdl/sagpd_front.sv
hdl/sagpd_back.sv
hdl/spatial_audio_gain_pan_doppler.sv
tb/spatial_audio_gain_pan_doppler_tb.sv
